### rtl/rdrt_pkg.sv
// ----------------------------------------------------------------------------
// rdrt_pkg: shared types and constants
// Record and running-table sizes, verdict and status codes, cell command types.
// ----------------------------------------------------------------------------
package rdrt_pkg;

    localparam int REC_CAP = 64;
    localparam int RUN_CAP = 16;
    localparam int REC_IW  = $clog2(REC_CAP);
    localparam int REC_CW  = $clog2(REC_CAP + 1);
    localparam int RUN_IW  = $clog2(RUN_CAP);
    localparam int RUN_CW  = $clog2(RUN_CAP + 1);

    localparam logic [2:0] VERDICT_START    = 3'd0;
    localparam logic [2:0] VERDICT_REPLAY   = 3'd1;
    localparam logic [2:0] VERDICT_SUPER    = 3'd2;
    localparam logic [2:0] VERDICT_RUNNING  = 3'd3;
    localparam logic [2:0] VERDICT_RUN_FULL = 3'd4;
    localparam logic [2:0] VERDICT_FINISHED = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd1;
    localparam logic [1:0] STATUS_OPEN  = 2'd2;
    localparam logic [1:0] STATUS_ENDS  = 2'd3;

    localparam logic CFG_RETENTION = 1'b0;
    localparam logic CFG_MAX_REC   = 1'b1;

    // broadcast command to every record cell
    typedef struct packed {
        logic              drop_rank;   // drop the cell holding rank sel_rank
        logic              touch;       // move matching key to newest rank
        logic              write_new;   // write new record into the free cell
        logic [REC_IW-1:0] sel_rank;
        logic [REC_CW-1:0] count;       // current count before the operation
        logic [7:0]        requester;
        logic [31:0]       session;
        logic [47:0]       sequence_v;
        logic [47:0]       stamp;
        logic [9:0]        status;
        logic [31:0]       handle;
    } rec_cmd_t;

    // result of one cell, passed along the chain
    typedef struct packed {
        logic              hit;
        logic              oldest;      // this cell holds rank 0
        logic              free_seen;
        logic              sel_hit;     // cell holding sel_rank found
        logic [REC_IW-1:0] free_idx;
        logic [REC_IW-1:0] hit_rank;
        logic [47:0]       sequence_v;
        logic [47:0]       stamp;
        logic [47:0]       old_stamp;
        logic [9:0]        status;
        logic [31:0]       handle;
    } rec_chain_t;

endpackage

### rtl/rdrt_rec_cell.sv
// ----------------------------------------------------------------------------
// rdrt_rec_cell: one record cell
// Holds one record with its age rank and merges its lookup into the chain.
// ----------------------------------------------------------------------------
module rdrt_rec_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rdrt_pkg::REC_IW-1:0]  cell_idx,
    input  rdrt_pkg::rec_cmd_t           cmd,
    input  logic                         is_free_pick,
    input  rdrt_pkg::rec_chain_t         chain_in,
    output rdrt_pkg::rec_chain_t         chain_out
);

    logic                        valid_reg;
    logic [7:0]                  req_reg;
    logic [31:0]                 ses_reg;
    logic [47:0]                 seq_reg;
    logic [47:0]                 stamp_reg;
    logic [9:0]                  status_reg;
    logic [31:0]                 handle_reg;
    logic [rdrt_pkg::REC_IW-1:0] rank_reg;
    logic                        key_hit;
    logic                        sel_hit;

    assign key_hit = valid_reg && req_reg == cmd.requester && ses_reg == cmd.session;
    assign sel_hit = valid_reg && rank_reg == cmd.sel_rank;

    // chain merge
    always_comb begin
        chain_out = chain_in;
        if (key_hit) begin
            chain_out.hit        = 1'b1;
            chain_out.hit_rank   = rank_reg;
            chain_out.sequence_v = seq_reg;
            chain_out.stamp      = stamp_reg;
            chain_out.status     = status_reg;
            chain_out.handle     = handle_reg;
        end
        if (valid_reg && rank_reg == '0) begin
            chain_out.oldest    = 1'b1;
            chain_out.old_stamp = stamp_reg;
        end
        if (!valid_reg && !chain_in.free_seen) begin
            chain_out.free_seen = 1'b1;
            chain_out.free_idx  = cell_idx;
        end
        if (sel_hit) chain_out.sel_hit = 1'b1;
    end

    // valid, rank and record update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.drop_rank && valid_reg) begin
            if (sel_hit) valid_reg <= 1'b0;
            else if (rank_reg > cmd.sel_rank) rank_reg <= rank_reg - 1'b1;
        end else if (cmd.touch && valid_reg) begin
            if (key_hit) begin
                rank_reg   <= rdrt_pkg::REC_IW'(cmd.count - 1'b1);
                seq_reg    <= cmd.sequence_v;
                stamp_reg  <= cmd.stamp;
                status_reg <= cmd.status;
                handle_reg <= cmd.handle;
            end else if (rank_reg > cmd.sel_rank) begin
                rank_reg <= rank_reg - 1'b1;
            end
        end else if (cmd.write_new && is_free_pick) begin
            valid_reg  <= 1'b1;
            rank_reg   <= rdrt_pkg::REC_IW'(cmd.count);
            req_reg    <= cmd.requester;
            ses_reg    <= cmd.session;
            seq_reg    <= cmd.sequence_v;
            stamp_reg  <= cmd.stamp;
            status_reg <= cmd.status;
            handle_reg <= cmd.handle;
        end
    end

endmodule

### rtl/rdrt_run_table.sv
// ----------------------------------------------------------------------------
// rdrt_run_table: running key table
// Lookup of running keys, insert at first free slot, clear on finish.
// ----------------------------------------------------------------------------
module rdrt_run_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [39:0] key,
    input  logic        insert,
    input  logic [47:0] insert_seq,
    input  logic        clear,
    output logic        hit,
    output logic        full,
    output logic [47:0] hit_seq
);

    logic [rdrt_pkg::RUN_CAP-1:0] valid_reg;
    logic [39:0]                  key_reg [rdrt_pkg::RUN_CAP];
    logic [47:0]                  seq_reg [rdrt_pkg::RUN_CAP];
    logic [rdrt_pkg::RUN_IW-1:0]  hit_idx;
    logic [rdrt_pkg::RUN_IW-1:0]  free_idx;
    logic                         free_seen;

    // first hit and first free slot
    always_comb begin
        hit = 1'b0; hit_idx = '0; hit_seq = '0; free_seen = 1'b0; free_idx = '0;
        for (int i = rdrt_pkg::RUN_CAP - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_reg[i] == key) begin
                hit = 1'b1; hit_idx = rdrt_pkg::RUN_IW'(i); hit_seq = seq_reg[i];
            end
            if (!valid_reg[i]) begin
                free_seen = 1'b1; free_idx = rdrt_pkg::RUN_IW'(i);
            end
        end
        full = !free_seen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (insert && free_seen) begin
            valid_reg[free_idx] <= 1'b1;
            key_reg[free_idx]   <= key;
            seq_reg[free_idx]   <= insert_seq;
        end else if (clear && hit) begin
            valid_reg[hit_idx] <= 1'b0;
        end
    end

endmodule

### rtl/retry_dedup_record_table.sv
// ----------------------------------------------------------------------------
// retry_dedup_record_table: duplicate request filter
// Channel  | direction | content
// s_axis   | in        | arrival or finish request
// m_axis   | out       | verdict for the request (none for stray finish)
// cfg      | in        | retention_ticks (0), max_records (1)
// An arrival goes through expiry, dropping expired records, then decide; a
// finish through decide, write, then eviction of records over the limit.
// The record cells form one combinational search chain; expiry and eviction
// drop one oldest record per cycle. Reset clears both tables at once. The
// result waits in the output register; the next request is taken once the
// current one has handed its result over.
// ----------------------------------------------------------------------------
module retry_dedup_record_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // requester[7:0] session[39:8] sequence_req[87:40] now[135:88]
    // outcome_error[143:136] answer_ref[175:144] txn_left_open[176]
    // ends_session[177], zero to 183
    input  logic [183:0] s_axis_tdata,
    input  logic         s_axis_tuser,      // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict[2:0] status_kind[4:3] error_code[12:5] answer_handle[44:13]
    // key_requester[52:45] key_session[84:53] early_eviction[85]
    // rollback_needed[86], zero to 87
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPIRE = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic         act_reg;
    logic [183:0] in_reg;
    logic [47:0]  ret_reg;
    logic [6:0]   maxrec_reg;
    logic [rdrt_pkg::REC_CW-1:0] count_reg, count_next;
    logic         evict_reg, evict_next;
    logic [87:0]  out_reg, out_next;
    logic [9:0]   fin_status_reg, fin_status_next;
    logic [31:0]  fin_handle_reg, fin_handle_next;

    logic [7:0]   req;
    logic [31:0]  ses;
    logic [47:0]  seq, now_v, age;
    logic [rdrt_pkg::REC_CW-1:0] limit;

    rdrt_pkg::rec_cmd_t   cmd;
    rdrt_pkg::rec_chain_t chain [rdrt_pkg::REC_CAP+1];
    logic run_hit, run_full, run_insert, run_clear;
    logic [47:0] run_seq;

    assign req   = in_reg[7:0];
    assign ses   = in_reg[39:8];
    assign seq   = in_reg[87:40];
    assign now_v = in_reg[135:88];
    assign age   = now_v - chain[rdrt_pkg::REC_CAP].old_stamp;
    assign limit = (maxrec_reg > 7'(rdrt_pkg::REC_CAP)) ?
                   rdrt_pkg::REC_CW'(rdrt_pkg::REC_CAP) : rdrt_pkg::REC_CW'(maxrec_reg);

    assign s_axis_tready = state_reg == ST_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = out_reg;

    // record cell chain
    assign chain[0] = '0;
    for (genvar g = 0; g < rdrt_pkg::REC_CAP; g++) begin : g_cell
        rdrt_rec_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .cell_idx(rdrt_pkg::REC_IW'(g)), .cmd(cmd),
            .is_free_pick(chain[rdrt_pkg::REC_CAP].free_seen &&
                          chain[rdrt_pkg::REC_CAP].free_idx == rdrt_pkg::REC_IW'(g)),
            .chain_in(chain[g]), .chain_out(chain[g+1])
        );
    end

    rdrt_run_table u_run (
        .aclk(aclk), .aresetn(aresetn), .key({req, ses}),
        .insert(run_insert), .insert_seq(seq), .clear(run_clear),
        .hit(run_hit), .full(run_full), .hit_seq(run_seq)
    );

    // control sequence
    always_comb begin
        state_next = state_reg; count_next = count_reg; evict_next = evict_reg;
        out_next = out_reg; fin_status_next = fin_status_reg;
        fin_handle_next = fin_handle_reg;
        cmd = '0;
        cmd.requester = req; cmd.session = ses; cmd.stamp = now_v;
        cmd.count = count_reg; cmd.status = fin_status_reg; cmd.handle = fin_handle_reg;
        cmd.sequence_v = run_seq;
        run_insert = 1'b0; run_clear = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                evict_next = 1'b0;
                if (s_axis_tvalid) state_next = s_axis_tuser ? ST_DECIDE : ST_EXPIRE;
            end
            ST_EXPIRE: begin
                if (count_reg != '0 && age >= ret_reg) begin
                    cmd.drop_rank = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                out_next = '0;
                out_next[52:45] = req;
                out_next[84:53] = ses;
                state_next = ST_OUT;
                if (!act_reg) begin
                    if (chain[rdrt_pkg::REC_CAP].hit &&
                        chain[rdrt_pkg::REC_CAP].sequence_v == seq) begin
                        out_next[2:0]  = rdrt_pkg::VERDICT_REPLAY;
                        out_next[4:3]  = chain[rdrt_pkg::REC_CAP].status[9:8];
                        out_next[12:5] = chain[rdrt_pkg::REC_CAP].status[7:0];
                        out_next[44:13] = chain[rdrt_pkg::REC_CAP].handle;
                    end else if (chain[rdrt_pkg::REC_CAP].hit &&
                                 seq < chain[rdrt_pkg::REC_CAP].sequence_v) begin
                        out_next[2:0] = rdrt_pkg::VERDICT_SUPER;
                    end else if (run_hit) begin
                        out_next[2:0] = rdrt_pkg::VERDICT_RUNNING;
                    end else if (run_full) begin
                        out_next[2:0] = rdrt_pkg::VERDICT_RUN_FULL;
                    end else begin
                        out_next[2:0] = rdrt_pkg::VERDICT_START;
                        run_insert = 1'b1;
                    end
                end else if (!run_hit) begin
                    state_next = ST_IDLE;
                end else begin
                    // finish: build status and record contents
                    fin_status_next = {(in_reg[143:136] == 8'd0) ? rdrt_pkg::STATUS_OK
                                       : rdrt_pkg::STATUS_ERROR, in_reg[143:136]};
                    fin_handle_next = (in_reg[143:136] == 8'd0) ? in_reg[175:144] : '0;
                    if (in_reg[176]) begin
                        fin_status_next = {rdrt_pkg::STATUS_OPEN, 8'd0};
                        fin_handle_next = '0;
                    end
                    if (in_reg[177]) begin
                        fin_status_next = {rdrt_pkg::STATUS_ENDS, 8'd0};
                        fin_handle_next = '0;
                    end
                    // make room when full with a new key
                    if (!chain[rdrt_pkg::REC_CAP].hit &&
                        count_reg == rdrt_pkg::REC_CW'(rdrt_pkg::REC_CAP)) begin
                        cmd.drop_rank = 1'b1;
                        count_next = count_reg - 1'b1;
                        evict_next = 1'b1;
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.sequence_v = run_seq;
                run_clear = 1'b1;
                if (chain[rdrt_pkg::REC_CAP].hit) begin
                    cmd.touch = 1'b1;
                    cmd.sel_rank = chain[rdrt_pkg::REC_CAP].hit_rank;
                end else begin
                    cmd.write_new = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_EVICT;
            end
            ST_EVICT: begin
                if (count_reg > limit) begin
                    cmd.drop_rank = 1'b1;
                    count_next = count_reg - 1'b1;
                    evict_next = 1'b1;
                end else begin
                    out_next = '0;
                    out_next[2:0]   = rdrt_pkg::VERDICT_FINISHED;
                    out_next[4:3]   = fin_status_reg[9:8];
                    out_next[12:5]  = fin_status_reg[7:0];
                    out_next[44:13] = fin_handle_reg;
                    out_next[52:45] = req;
                    out_next[84:53] = ses;
                    out_next[85]    = evict_reg;
                    out_next[86]    = in_reg[176];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            evict_reg  <= 1'b0;
            ret_reg    <= 48'd1000000000;
            maxrec_reg <= 7'd64;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            evict_reg <= evict_next;
            if (cfg_valid) begin
                if (cfg_index == rdrt_pkg::CFG_RETENTION) ret_reg <= cfg_data;
                else maxrec_reg <= cfg_data[6:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg        <= out_next;
        fin_status_reg <= fin_status_next;
        fin_handle_reg <= fin_handle_next;
        if (s_axis_tvalid && s_axis_tready) begin
            in_reg  <= s_axis_tdata;
            act_reg <= s_axis_tuser;
        end
    end

endmodule

### rtl/rdrt_checker.sv
// ----------------------------------------------------------------------------
// rdrt_checker: port checks
// Watches the stream ports of the filter for ordering and protocol slips.
// ----------------------------------------------------------------------------
module rdrt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [87:0]  m_axis_tdata
);

    // result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // verdict in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= rdrt_pkg::VERDICT_FINISHED)
        else $error("verdict out of range");

    // no new request taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken with result pending");

    // flags only on finished verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != rdrt_pkg::VERDICT_FINISHED
        |-> m_axis_tdata[86:85] == 2'b00)
        else $error("finish flags on other verdict");

endmodule

bind retry_dedup_record_table rdrt_checker u_rdrt_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

### tb/sv/retry_dedup_record_checker.sv
// ----------------------------------------------------------------------------
// retry_dedup_record_checker: result predictor and scoreboard
// Watches the request, config and result channels of the duplicate filter,
// keeps its own copy of the record and running tables, predicts the verdict
// of every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module retry_dedup_record_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [183:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data,
    output int           fail_count,
    output int           verdicts_pending
);

    typedef struct {
        logic [2:0]  verdict;
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [31:0] handle;
        logic [7:0]  req;
        logic [31:0] ses;
        logic        evict;
        logic        rollback;
    } verdict_t;

    verdict_t verdict_q[$];

    // configuration copy
    logic [47:0] keep_ticks;
    logic [6:0]  rec_limit;

    // record table copy
    bit          rv[rdrt_pkg::REC_CAP];
    logic [7:0]  rq[rdrt_pkg::REC_CAP];
    logic [31:0] rs[rdrt_pkg::REC_CAP];
    logic [47:0] rsq[rdrt_pkg::REC_CAP];
    logic [47:0] rst[rdrt_pkg::REC_CAP];
    logic [9:0]  rstat[rdrt_pkg::REC_CAP];
    logic [31:0] rh[rdrt_pkg::REC_CAP];
    int          rrank[rdrt_pkg::REC_CAP];

    // running table copy
    bit          uv[rdrt_pkg::RUN_CAP];
    logic [39:0] uk[rdrt_pkg::RUN_CAP];
    logic [47:0] useq[rdrt_pkg::RUN_CAP];

    assign verdicts_pending = verdict_q.size();

    function automatic int rec_count();
        int n;
        n = 0;
        for (int i = 0; i < rdrt_pkg::REC_CAP; i++) n += rv[i];
        return n;
    endfunction

    function automatic int rec_find(logic [7:0] req, logic [31:0] ses);
        for (int i = 0; i < rdrt_pkg::REC_CAP; i++)
            if (rv[i] && rq[i] == req && rs[i] == ses) return i;
        return -1;
    endfunction

    function automatic int rec_oldest();
        int best;
        best = -1;
        for (int i = 0; i < rdrt_pkg::REC_CAP; i++)
            if (rv[i] && (best < 0 || rrank[i] < rrank[best])) best = i;
        return best;
    endfunction

    function automatic void close_gap(int r, int skip);
        for (int i = 0; i < rdrt_pkg::REC_CAP; i++)
            if (i != skip && rv[i] && rrank[i] > r) rrank[i]--;
    endfunction

    function automatic void rec_drop(int i);
        rv[i] = 0;
        close_gap(rrank[i], i);
    endfunction

    // write the outcome of a finished key, returns 1 if any record left early
    function automatic bit rec_store(logic [7:0] req, logic [31:0] ses, logic [47:0] sq,
                                     logic [9:0] stat, logic [31:0] hd, logic [47:0] stamp);
        bit ev;
        int idx;
        int o;
        int lim;
        ev = 0;
        idx = rec_find(req, ses);
        if (idx < 0) begin
            if (rec_count() >= rdrt_pkg::REC_CAP) begin
                o = rec_oldest();
                if (o >= 0) rec_drop(o);
                ev = 1;
            end
            for (int i = 0; i < rdrt_pkg::REC_CAP; i++)
                if (!rv[i]) begin
                    idx = i;
                    break;
                end
            if (idx < 0) return ev;
            rrank[idx] = rec_count();
            rv[idx] = 1;
            rq[idx] = req;
            rs[idx] = ses;
        end else begin
            close_gap(rrank[idx], idx);
            rrank[idx] = rec_count() - 1;
        end
        rsq[idx] = sq;
        rstat[idx] = stat;
        rh[idx] = hd;
        rst[idx] = stamp;
        lim = (int'(rec_limit) < rdrt_pkg::REC_CAP) ? int'(rec_limit) : rdrt_pkg::REC_CAP;
        while (rec_count() > lim) begin
            o = rec_oldest();
            if (o < 0) break;
            rec_drop(o);
            ev = 1;
        end
        return ev;
    endfunction

    // work out the verdict for one accepted request
    task automatic predict_verdict(logic act, logic [183:0] d);
        logic [7:0]  req;
        logic [31:0] ses;
        logic [47:0] sq;
        logic [47:0] stamp;
        logic [7:0]  err;
        logic [31:0] ans;
        logic        open_txn;
        logic        ends;
        logic [47:0] age;
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [31:0] hd;
        int          run;
        int          r;
        int          o;
        bit          ev;
        verdict_t    v;
        req = d[7:0];
        ses = d[39:8];
        sq = d[87:40];
        stamp = d[135:88];
        err = d[143:136];
        ans = d[175:144];
        open_txn = d[176];
        ends = d[177];
        run = -1;
        for (int i = 0; i < rdrt_pkg::RUN_CAP; i++)
            if (uv[i] && uk[i] == {req, ses}) begin
                run = i;
                break;
            end
        v = '{rdrt_pkg::VERDICT_START, rdrt_pkg::STATUS_OK, 8'h00, 32'h0, req, ses,
              1'b0, 1'b0};

        if (act == 1'b0) begin
            // age out from the oldest record
            for (int n = 0; n < rdrt_pkg::REC_CAP; n++) begin
                o = rec_oldest();
                if (o < 0) break;
                age = stamp - rst[o];
                if (age < keep_ticks) break;
                rec_drop(o);
            end
            r = rec_find(req, ses);
            if (r >= 0 && rsq[r] == sq) begin
                v.verdict = rdrt_pkg::VERDICT_REPLAY;
                v.kind = rstat[r][9:8];
                v.code = rstat[r][7:0];
                v.handle = rh[r];
            end else if (r >= 0 && sq < rsq[r]) begin
                v.verdict = rdrt_pkg::VERDICT_SUPER;
            end else if (run >= 0) begin
                v.verdict = rdrt_pkg::VERDICT_RUNNING;
            end else begin
                v.verdict = rdrt_pkg::VERDICT_RUN_FULL;
                for (int i = 0; i < rdrt_pkg::RUN_CAP; i++)
                    if (!uv[i]) begin
                        uv[i] = 1;
                        uk[i] = {req, ses};
                        useq[i] = sq;
                        v.verdict = rdrt_pkg::VERDICT_START;
                        break;
                    end
            end
            verdict_q.push_back(v);
        end else if (run >= 0) begin
            // finish of a running key
            uv[run] = 0;
            kind = (err == 0) ? rdrt_pkg::STATUS_OK : rdrt_pkg::STATUS_ERROR;
            code = err;
            hd = (err == 0) ? ans : 32'h0;
            if (open_txn) begin
                kind = rdrt_pkg::STATUS_OPEN;
                code = 8'h00;
                hd = 32'h0;
            end
            if (ends) begin
                kind = rdrt_pkg::STATUS_ENDS;
                code = 8'h00;
                hd = 32'h0;
            end
            ev = rec_store(req, ses, useq[run], {kind, code}, hd, stamp);
            v.verdict = rdrt_pkg::VERDICT_FINISHED;
            v.kind = kind;
            v.code = code;
            v.handle = hd;
            v.evict = ev;
            v.rollback = open_txn;
            verdict_q.push_back(v);
        end
    endtask

    function automatic int field_differs(string name, longint unsigned e,
                                         longint unsigned a);
        if (e == a) return 0;
        $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, name, e, a);
        return 1;
    endfunction

    // sample every channel at the rising edge
    always @(posedge aclk) begin
        verdict_t v;
        int bad;
        if (!aresetn) begin
            keep_ticks <= 48'd1000000000;
            rec_limit <= 7'd64;
            fail_count <= 0;
            verdict_q.delete();
            for (int i = 0; i < rdrt_pkg::REC_CAP; i++) rv[i] = 0;
            for (int i = 0; i < rdrt_pkg::RUN_CAP; i++) uv[i] = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rdrt_pkg::CFG_RETENTION) keep_ticks <= cfg_data;
                else if (cfg_index == rdrt_pkg::CFG_MAX_REC) rec_limit <= cfg_data[6:0];
            end
            if (s_axis_tvalid && s_axis_tready) predict_verdict(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time,
                             m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    // oldest expected transaction
                    v = verdict_q[0];
                    verdict_q.delete(0);
                    bad = 0;
                    bad += field_differs("verdict", v.verdict, m_axis_tdata[2:0]);
                    bad += field_differs("status_kind", v.kind, m_axis_tdata[4:3]);
                    bad += field_differs("error_code", v.code, m_axis_tdata[12:5]);
                    bad += field_differs("answer_handle", v.handle, m_axis_tdata[44:13]);
                    bad += field_differs("key_requester", v.req, m_axis_tdata[52:45]);
                    bad += field_differs("key_session", v.ses, m_axis_tdata[84:53]);
                    bad += field_differs("early_eviction", v.evict, m_axis_tdata[85]);
                    bad += field_differs("rollback_needed", v.rollback, m_axis_tdata[86]);
                    bad += field_differs("padding", 0, m_axis_tdata[87]);
                    if (bad != 0) fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

### tb/sv/retry_dedup_record_table_tb.sv
// ----------------------------------------------------------------------------
// retry_dedup_record_table_tb: testbench top for the duplicate filter
// Drives directed and random arrival/finish traffic over several retention
// and record limit settings, with random stalls on both channels; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module retry_dedup_record_table_tb;

    localparam int QUIET_CYCLES = 80;
    localparam int STALL_LIMIT  = 3000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = rdrt_pkg::CFG_RETENTION;
    logic [47:0]  cfg_data = '0;

    int          fail_count;
    int          verdicts_pending;
    bit          idling_on = 1;
    int          sink_stall = 0;
    int          quiet_cycles = 0;
    logic [47:0] tick_now = '0;

    // key pool for well-formed request sequences
    logic [7:0]  pool_req[128];
    logic [31:0] pool_ses[128];
    logic [47:0] pool_seq[128];
    int          launched[$];

    always #6 aclk = ~aclk;

    retry_dedup_record_table DUT (.*);

    retry_dedup_record_checker checker_i (.*);

    // result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            sink_stall <= int'($urandom_range(0, 5));
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(logic act, logic [7:0] req, logic [31:0] ses,
                                logic [47:0] sq, logic [7:0] err, logic [31:0] ans,
                                logic open_txn, logic ends);
        int gap;
        gap = (idling_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 6)) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {6'b0, ends, open_txn, ans, err, tick_now, sq, ses, req};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(logic [47:0] keep, logic [6:0] limit, int keys,
                                int items, int step);
        int k;
        int pick;
        int sel;
        logic [47:0] sq;
        settle();
        write_reg(rdrt_pkg::CFG_RETENTION, keep);
        write_reg(rdrt_pkg::CFG_MAX_REC, {41'b0, limit});
        launched.delete();
        for (int i = 0; i < keys; i++) begin
            pool_req[i] = 8'($urandom);
            pool_ses[i] = 32'($urandom);
            pool_seq[i] = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFF0;
        end
        for (int n = 0; n < items; n++) begin
            sel = int'($urandom_range(0, 99));
            if (sel < 8) begin
                // noise: anything at all
                send_request(1'($urandom), 8'($urandom), 32'($urandom),
                             48'({$urandom, $urandom}), 8'($urandom), 32'($urandom),
                             1'($urandom), 1'($urandom));
            end else if (sel < 55 || launched.size() == 0) begin
                k = int'($urandom_range(0, keys - 1));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: sq = pool_seq[k] + 48'd1;
                    6, 7:             sq = pool_seq[k];
                    8:                sq = pool_seq[k] - 48'($urandom_range(1, 3));
                    default:          sq = 48'({$urandom, $urandom});
                endcase
                if (sq > pool_seq[k]) pool_seq[k] = sq;
                launched.push_back(k);
                send_request(1'b0, pool_req[k], pool_ses[k], sq, 8'($urandom),
                             32'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                pick = int'($urandom_range(0, launched.size() - 1));
                k = launched[pick];
                launched.delete(pick);
                send_request(1'b1, pool_req[k], pool_ses[k], 48'({$urandom, $urandom}),
                             ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom),
                             32'($urandom), $urandom_range(0, 4) == 0,
                             $urandom_range(0, 5) == 0);
            end
            if ($urandom_range(0, 49) == 0) tick_now = 48'({$urandom, $urandom});
            else tick_now = tick_now + 48'($urandom_range(0, step));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: replay, superseded, still running, stray finish, flag combos
        send_request(1'b0, 8'h00, 32'h0, 48'h0, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b0, 8'h00, 32'h0, 48'h0, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b1, 8'h00, 32'h0, 48'h0, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_request(1'b0, 8'h00, 32'h0, 48'h0, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b1, 8'hFF, 32'hFFFF_FFFF, 48'h0, 8'h00, 32'h1, 1'b0, 1'b0);
        send_request(1'b0, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF,
                     32'hFFFF_FFFF, 1'b1, 1'b1);
        send_request(1'b1, 8'hFF, 32'hFFFF_FFFF, 48'h0, 8'hFF, 32'h1234, 1'b1, 1'b0);
        send_request(1'b0, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'h00, 32'h0,
                     1'b0, 1'b0);
        send_request(1'b0, 8'hFF, 32'hFFFF_FFFF, 48'h5, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b0, 8'h00, 32'h0, 48'h7, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b1, 8'h00, 32'h0, 48'h0, 8'h81, 32'h55, 1'b1, 1'b1);
        send_request(1'b0, 8'h00, 32'h0, 48'h7, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b0, 8'h5A, 32'h1234_5678, 48'h1, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b1, 8'h5A, 32'h1234_5678, 48'h0, 8'h2A, 32'h77, 1'b0, 1'b0);
        send_request(1'b0, 8'h5A, 32'h1234_5678, 48'h1, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b1, 8'hA5, 32'h8765_4321, 48'h0, 8'h00, 32'h0, 1'b0, 1'b1);
        // jump to the top of time: every record ages out
        tick_now = 48'hFFFF_FFFF_FFFF;
        send_request(1'b0, 8'h00, 32'h0, 48'h7, 8'h00, 32'h0, 1'b0, 1'b0);
        send_request(1'b1, 8'h00, 32'h0, 48'h0, 8'h00, 32'hCAFE, 1'b0, 1'b0);
        send_request(1'b0, 8'h00, 32'h0, 48'h7, 8'h00, 32'h0, 1'b0, 1'b0);

        random_phase(48'd1000000000, 7'd64, 20, 250, 1000);
        random_phase(48'd0, 7'd1, 12, 150, 10);
        random_phase(48'd300, 7'd3, 16, 200, 100);
        random_phase(48'hFFFF_FFFF_FFFF, 7'd127, 90, 350, 1000);
        random_phase(48'd1, 7'd0, 10, 100, 3);
        idling_on = 0;
        random_phase(48'd5000, 7'd64, 30, 250, 200);

        settle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
